FILE: src/bale_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the bounded array list engine.
// Used by the controller, the datapath, the top level and the checker.
package bale_pkg;

  localparam int DEPTH    = 16;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = 5;
  localparam int SLOT_W   = 4;
  localparam int WORD_W   = 32;
  localparam int CAP_LIM  = (DEPTH < 16) ? DEPTH : 16;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_SET    = 3'd2;
  localparam logic [2:0] OP_GET    = 3'd3;
  localparam logic [2:0] OP_SEARCH = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  typedef enum logic [1:0] {WA_FILL, WA_POS, WA_IDX} waddr_sel_e;
  typedef enum logic [1:0] {RA_POS, RA_IDX_M1, RA_IDX} raddr_sel_e;
  typedef enum logic [1:0] {SL_ZERO, SL_POS, SL_FILL, SL_PEND} slot_sel_e;
  typedef enum logic [1:0] {WD_ZERO, WD_ITEM, WD_RDATA, WD_PEND} word_sel_e;

  typedef struct packed {
    logic       latch;
    logic       mem_we;
    waddr_sel_e waddr_sel;
    logic       wdata_rd;
    logic       mem_re;
    raddr_sel_e raddr_sel;
    logic       count_inc;
    logic       idx_load_top;
    logic       idx_clr;
    logic       idx_dec;
    logic       idx_inc;
    logic       pend_clr;
    logic       pend_set;
    logic       emit;
    logic [1:0] emit_status;
    slot_sel_e  emit_slot;
    word_sel_e  emit_word;
    logic       emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       pos_gt_fill;
    logic       pos_ge_cap;
    logic       get_range;
    logic       idx_gt_pos;
    logic       idx_lt_cap;
    logic       match;
    logic       pend_valid;
    logic       out_free;
  } dp_status_t;

endpackage

FILE: src/bale_dp.sv
`timescale 1ns / 1ps
// Datapath: slot store with valid bits, fill count, capacity register,
// scan index, pending match and output register. Depends on bale_pkg.
module bale_dp import bale_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [2:0]               operation_i,
  input  logic [SLOT_W-1:0]        position_i,
  input  logic signed [WORD_W-1:0] data_word_i,
  input  logic                     cfg_we_i,
  input  logic [CNT_W-1:0]         cfg_wdata_i,
  input  ctrl_cmd_t                cmd_i,
  output dp_status_t               stat_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [1:0]               status_o,
  output logic [SLOT_W-1:0]        slot_o,
  output logic signed [WORD_W-1:0] read_word_o,
  output logic [CNT_W-1:0]         entry_count_o,
  output logic                     last_o
);

  localparam logic [CNT_W-1:0] CapLim = CNT_W'(CAP_LIM);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [WORD_W-1:0] rdata_q;
  logic              rok_q;
  logic [WORD_W-1:0] rd_word;

  logic [2:0]               op_q;
  logic [SLOT_W-1:0]        pos_q;
  logic signed [WORD_W-1:0] word_q;

  logic [CNT_W-1:0] cfg_q;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_ext;

  logic              pend_q, pend_d;
  logic [SLOT_W-1:0] pend_slot_q;
  logic [WORD_W-1:0] pend_word_q;

  logic [ADDR_W-1:0] waddr, raddr;
  logic [WORD_W-1:0] wdata;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_status_q;
  logic [SLOT_W-1:0] out_slot_q, slot_sel;
  logic [WORD_W-1:0] out_word_q, word_sel;
  logic [CNT_W-1:0]  out_count_q;
  logic              out_last_q;

  assign pos_ext = CNT_W'(pos_q);
  assign rd_word = rok_q ? rdata_q : '0;

  always_comb begin
    if (cfg_q == '0) begin
      cap = CNT_W'(1);
    end else if (cfg_q > CapLim) begin
      cap = CapLim;
    end else begin
      cap = cfg_q;
    end
  end

  always_comb begin
    case (cmd_i.waddr_sel)
      WA_FILL: waddr = ADDR_W'(fill_q);
      WA_POS:  waddr = ADDR_W'(pos_q);
      default: waddr = ADDR_W'(idx_q);
    endcase
    case (cmd_i.raddr_sel)
      RA_POS:    raddr = ADDR_W'(pos_q);
      RA_IDX_M1: raddr = ADDR_W'(idx_q - CNT_W'(1));
      default:   raddr = ADDR_W'(idx_q);
    endcase
    wdata = cmd_i.wdata_rd ? rd_word : word_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.mem_re) begin
      rdata_q <= mem_q[raddr];
    end
    if (cmd_i.latch) begin
      op_q   <= operation_i;
      pos_q  <= position_i;
      word_q <= data_word_i;
    end
    if (cmd_i.pend_set) begin
      pend_slot_q <= SLOT_W'(idx_q);
      pend_word_q <= rd_word;
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.emit_status;
      out_slot_q   <= slot_sel;
      out_word_q   <= word_sel;
      out_count_q  <= fill_d;
      out_last_q   <= cmd_i.emit_last;
    end
  end

  always_comb begin
    fill_d = cmd_i.count_inc ? fill_q + CNT_W'(1) : fill_q;
    idx_d  = idx_q;
    if (cmd_i.idx_load_top) begin
      idx_d = cap - CNT_W'(1);
    end else if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - CNT_W'(1);
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CNT_W'(1);
    end
    pend_d = pend_q;
    if (cmd_i.pend_clr) begin
      pend_d = 1'b0;
    end else if (cmd_i.pend_set) begin
      pend_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    case (cmd_i.emit_slot)
      SL_POS:  slot_sel = pos_q;
      SL_FILL: slot_sel = SLOT_W'(fill_q);
      SL_PEND: slot_sel = pend_slot_q;
      default: slot_sel = '0;
    endcase
    case (cmd_i.emit_word)
      WD_ITEM:  word_sel = word_q;
      WD_RDATA: word_sel = rd_word;
      WD_PEND:  word_sel = pend_word_q;
      default:  word_sel = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rok_q       <= 1'b0;
      cfg_q       <= CNT_W'(16);
      fill_q      <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.mem_we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (cmd_i.mem_re) begin
        rok_q <= valid_q[raddr];
      end
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o.op          = op_q;
  assign stat_o.full        = (fill_q >= cap);
  assign stat_o.pos_gt_fill = (pos_ext > fill_q);
  assign stat_o.pos_ge_cap  = (pos_ext >= cap);
  assign stat_o.get_range   = (pos_ext >= fill_q) || (32'(pos_q) >= 32'(DEPTH));
  assign stat_o.idx_gt_pos  = (idx_q > pos_ext);
  assign stat_o.idx_lt_cap  = (idx_q < cap);
  assign stat_o.match       = (rd_word == word_q);
  assign stat_o.pend_valid  = pend_q;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_o        = out_slot_q;
  assign read_word_o   = out_word_q;
  assign entry_count_o = out_count_q;
  assign last_o        = out_last_q;

endmodule

FILE: src/bale_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences each operation over the datapath.
// Drives ctrl_cmd_t and reads dp_status_t, both from bale_pkg.
module bale_ctrl import bale_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_SH_RD   = 3'd2;
  localparam logic [2:0] S_SH_WR   = 3'd3;
  localparam logic [2:0] S_INS_FIN = 3'd4;
  localparam logic [2:0] S_GET     = 3'd5;
  localparam logic [2:0] S_SR_RD   = 3'd6;
  localparam logic [2:0] S_SR_CMP  = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
          case (stat_i.op)
            OP_APPEND: begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              if (stat_i.full) begin
                cmd_o.emit_status = ST_FULL;
                cmd_o.emit_slot   = SL_ZERO;
                cmd_o.emit_word   = WD_ZERO;
              end else begin
                cmd_o.mem_we      = 1'b1;
                cmd_o.waddr_sel   = WA_FILL;
                cmd_o.count_inc   = 1'b1;
                cmd_o.emit_status = ST_OK;
                cmd_o.emit_slot   = SL_FILL;
                cmd_o.emit_word   = WD_ITEM;
              end
            end
            OP_INSERT: begin
              if (stat_i.full || stat_i.pos_gt_fill) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_last   = 1'b1;
                cmd_o.emit_status = stat_i.full ? ST_FULL : ST_RANGE;
                cmd_o.emit_slot   = SL_POS;
                cmd_o.emit_word   = WD_ZERO;
              end else begin
                cmd_o.idx_load_top = 1'b1;
                state_d            = S_SH_RD;
              end
            end
            OP_SET: begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              cmd_o.emit_slot = SL_POS;
              if (stat_i.pos_ge_cap) begin
                cmd_o.emit_status = ST_RANGE;
                cmd_o.emit_word   = WD_ZERO;
              end else begin
                cmd_o.mem_we      = 1'b1;
                cmd_o.waddr_sel   = WA_POS;
                cmd_o.emit_status = ST_OK;
                cmd_o.emit_word   = WD_ITEM;
              end
            end
            OP_GET: begin
              if (stat_i.get_range) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_last   = 1'b1;
                cmd_o.emit_status = ST_RANGE;
                cmd_o.emit_slot   = SL_POS;
                cmd_o.emit_word   = WD_ZERO;
              end else begin
                cmd_o.mem_re    = 1'b1;
                cmd_o.raddr_sel = RA_POS;
                state_d         = S_GET;
              end
            end
            OP_SEARCH: begin
              cmd_o.pend_clr = 1'b1;
              cmd_o.idx_clr  = 1'b1;
              state_d        = S_SR_RD;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SH_RD: begin
        if (stat_i.idx_gt_pos) begin
          cmd_o.mem_re    = 1'b1;
          cmd_o.raddr_sel = RA_IDX_M1;
          state_d         = S_SH_WR;
        end else begin
          state_d = S_INS_FIN;
        end
      end
      S_SH_WR: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.waddr_sel = WA_IDX;
        cmd_o.wdata_rd  = 1'b1;
        cmd_o.idx_dec   = 1'b1;
        state_d         = S_SH_RD;
      end
      S_INS_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.mem_we      = 1'b1;
          cmd_o.waddr_sel   = WA_POS;
          cmd_o.count_inc   = 1'b1;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = ST_OK;
          cmd_o.emit_slot   = SL_POS;
          cmd_o.emit_word   = WD_ITEM;
          state_d           = S_IDLE;
        end
      end
      S_GET: begin
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = ST_OK;
          cmd_o.emit_slot   = SL_POS;
          cmd_o.emit_word   = WD_RDATA;
          state_d           = S_IDLE;
        end
      end
      S_SR_RD: begin
        if (stat_i.idx_lt_cap) begin
          cmd_o.mem_re    = 1'b1;
          cmd_o.raddr_sel = RA_IDX;
          state_d         = S_SR_CMP;
        end else if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          if (stat_i.pend_valid) begin
            cmd_o.emit_status = ST_OK;
            cmd_o.emit_slot   = SL_PEND;
            cmd_o.emit_word   = WD_PEND;
          end else begin
            cmd_o.emit_status = ST_NONE;
            cmd_o.emit_slot   = SL_ZERO;
            cmd_o.emit_word   = WD_ZERO;
          end
          state_d = S_IDLE;
        end
      end
      S_SR_CMP: begin
        if (!stat_i.match) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SR_RD;
        end else if (!stat_i.pend_valid || stat_i.out_free) begin
          if (stat_i.pend_valid) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_last   = 1'b0;
            cmd_o.emit_status = ST_OK;
            cmd_o.emit_slot   = SL_PEND;
            cmd_o.emit_word   = WD_PEND;
          end
          cmd_o.pend_set = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          state_d        = S_SR_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/bounded_array_list_engine.sv
`timescale 1ns / 1ps
// Bounded array list engine: a list of up to sixteen signed 32-bit words in a
// single-port store with registered read. One word is taken at a time. Insert
// shifts the slots from the top of capacity down to the position one by one, and
// search reads and compares every slot below capacity in turn; the engine holds
// before each result while the output side stalls. The one store port moves or
// compares one slot at a time. A new word is taken while the last result still
// waits in the output register. No clearing pass: per-slot valid bits make the
// store read as zero from reset. Depends on bale_pkg, bale_ctrl and bale_dp.
module bounded_array_list_engine import bale_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               operation_i,
  input  logic [SLOT_W-1:0]        position_i,
  input  logic signed [WORD_W-1:0] data_word_i,
  input  logic                     cfg_we_i,
  input  logic [CNT_W-1:0]         cfg_wdata_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic [SLOT_W-1:0]        slot_o,
  output logic signed [WORD_W-1:0] read_word_o,
  output logic [CNT_W-1:0]         entry_count_o,
  output logic                     last_o
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  bale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bale_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .data_word_i   (data_word_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .read_word_o   (read_word_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o)
  );

endmodule

FILE: src/bale_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the bounded array list engine, bound to its top.
// Depends on bale_pkg.
module bale_checker import bale_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic [2:0]               operation_i,
  input logic [SLOT_W-1:0]        position_i,
  input logic signed [WORD_W-1:0] data_word_i,
  input logic                     cfg_we_i,
  input logic [CNT_W-1:0]         cfg_wdata_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [1:0]               status_o,
  input logic [SLOT_W-1:0]        slot_o,
  input logic signed [WORD_W-1:0] read_word_o,
  input logic [CNT_W-1:0]         entry_count_o,
  input logic                     last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(slot_o) && $stable(read_word_o) && $stable(entry_count_o) && $stable(last_o))
    else $error("result word changed while stalled");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in work");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= CNT_W'(CAP_LIM))
    else $error("entry count above capacity limit");

  a_none_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NONE |-> last_o && slot_o == '0 && read_word_o == '0)
    else $error("malformed not-found result");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_RANGE) |->
    last_o && read_word_o == '0)
    else $error("malformed error result");

endmodule

bind bounded_array_list_engine bale_checker u_bale_checker (.*);

FILE: tb/bale_list_checker.sv
`timescale 1ns / 1ps
// Checker for the bounded array list engine: watches the operation, result and
// capacity ports, keeps a shadow copy of the list and compares every result.
// Depends on bale_pkg.
module bale_list_checker import bale_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [2:0]               operation_i,
  input  logic [SLOT_W-1:0]        position_i,
  input  logic signed [WORD_W-1:0] data_word_i,
  input  logic                     cfg_we_i,
  input  logic [CNT_W-1:0]         cfg_wdata_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [1:0]               status_i,
  input  logic [SLOT_W-1:0]        slot_i,
  input  logic signed [WORD_W-1:0] read_word_i,
  input  logic [CNT_W-1:0]         entry_count_i,
  input  logic                     last_i,
  output int                       fail_count_o,
  output int                       waiting_o,
  output int                       checked_o
);

  typedef struct {
    logic [1:0]               status;
    logic [SLOT_W-1:0]        slot;
    logic signed [WORD_W-1:0] word;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } list_result_t;

  logic signed [WORD_W-1:0] shadow_store [DEPTH];
  logic [CNT_W-1:0]         shadow_fill;
  logic [CNT_W-1:0]         shadow_cap;
  list_result_t             expected_results [$];

  function automatic int usable_slots();
    int c;
    c = shadow_cap;
    if (c < 1) c = 1;
    if (c > CAP_LIM) c = CAP_LIM;
    return c;
  endfunction

  task automatic queue_result(input logic [1:0] status, input int slot,
                              input logic [WORD_W-1:0] word, input logic last);
    list_result_t r;
    r.status = status;
    r.slot   = SLOT_W'(slot);
    r.word   = word;
    r.count  = shadow_fill;
    r.last   = last;
    expected_results.push_back(r);
  endtask

  task automatic apply_list_op(input logic [2:0] op, input logic [SLOT_W-1:0] pos,
                               input logic [WORD_W-1:0] word);
    int cap;
    int idx;
    int i;
    int hits [$];
    cap = usable_slots();
    case (op)
      OP_APPEND: begin
        if (shadow_fill >= cap) begin
          queue_result(ST_FULL, 0, '0, 1'b1);
        end else begin
          idx = shadow_fill;
          shadow_store[idx] = word;
          shadow_fill = shadow_fill + 1'b1;
          queue_result(ST_OK, idx, word, 1'b1);
        end
      end
      OP_INSERT: begin
        if (shadow_fill >= cap) begin
          queue_result(ST_FULL, pos, '0, 1'b1);
        end else if (pos > shadow_fill) begin
          queue_result(ST_RANGE, pos, '0, 1'b1);
        end else begin
          for (i = cap - 1; i > int'(pos); i--) shadow_store[i] = shadow_store[i-1];
          shadow_store[pos] = word;
          shadow_fill = shadow_fill + 1'b1;
          queue_result(ST_OK, pos, word, 1'b1);
        end
      end
      OP_SET: begin
        if (int'(pos) >= cap) begin
          queue_result(ST_RANGE, pos, '0, 1'b1);
        end else begin
          shadow_store[pos] = word;
          queue_result(ST_OK, pos, word, 1'b1);
        end
      end
      OP_GET: begin
        if (pos >= shadow_fill || int'(pos) >= DEPTH) begin
          queue_result(ST_RANGE, pos, '0, 1'b1);
        end else begin
          queue_result(ST_OK, pos, shadow_store[pos], 1'b1);
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < cap; i++) begin
          if (shadow_store[i] == word) hits.push_back(i);
        end
        if (hits.size() == 0) begin
          queue_result(ST_NONE, 0, '0, 1'b1);
        end else begin
          foreach (hits[k]) begin
            queue_result(ST_OK, hits[k], shadow_store[hits[k]], k == hits.size() - 1);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] exp_val,
                             input logic [WORD_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t exp_r;
    if (!rst_ni) begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      shadow_fill  = '0;
      shadow_cap   = CNT_W'(16);
      fail_count_o = 0;
      checked_o    = 0;
      expected_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: status %0d slot %0d word 0x%0h",
                 status_i, slot_i, read_word_i);
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", exp_r.status, status_i);
          check_field("slot", exp_r.slot, slot_i);
          check_field("read_word", exp_r.word, read_word_i);
          check_field("entry_count", exp_r.count, entry_count_i);
          check_field("last", exp_r.last, last_i);
          checked_o++;
        end
      end
      if (cfg_we_i) shadow_cap = cfg_wdata_i;
      if (in_valid_i && in_ready_i) apply_list_op(operation_i, position_i, data_word_i);
    end
    waiting_o = expected_results.size();
  end

endmodule

FILE: tb/tb_bounded_array_list_engine.sv
`timescale 1ns / 1ps
// Testbench top for the bounded array list engine: drives directed and random
// list operations and capacity writes under varying handshake pressure.
// Depends on bale_pkg, the engine RTL and bale_list_checker.
module tb_bounded_array_list_engine;
  import bale_pkg::*;

  localparam int LIMIT  = 300000;
  localparam int SETTLE = 48;

  localparam logic [2:0] OP_UNDEF_LO = 3'd5;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [2:0]               operation_i;
  logic [SLOT_W-1:0]        position_i;
  logic signed [WORD_W-1:0] data_word_i;
  logic                     cfg_we_i;
  logic [CNT_W-1:0]         cfg_wdata_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [1:0]               status_o;
  logic [SLOT_W-1:0]        slot_o;
  logic signed [WORD_W-1:0] read_word_o;
  logic [CNT_W-1:0]         entry_count_o;
  logic                     last_o;

  int fail_count;
  int waiting;
  int checked;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int ops_sent    = 0;
  int cap_writes  = 0;

  logic [WORD_W-1:0] word_pool [4] = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff};
  logic [CNT_W-1:0]  phase_cap [4] = '{5'd16, 5'd31, 5'd1, 5'd17};
  int                phase_idle [4] = '{0, 55, 0, 36};
  int                phase_stall [4] = '{0, 0, 55, 36};

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  bounded_array_list_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .data_word_i   (data_word_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .read_word_o   (read_word_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o)
  );

  bale_list_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .data_word_i   (data_word_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status_o),
    .slot_i        (slot_o),
    .read_word_i   (read_word_o),
    .entry_count_i (entry_count_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .waiting_o     (waiting),
    .checked_o     (checked)
  );

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Call at a falling edge; returns at the falling edge after the word is taken.
  task automatic push_op(input logic [2:0] op, input logic [SLOT_W-1:0] pos,
                         input logic [WORD_W-1:0] word);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    operation_i = op;
    position_i  = pos;
    data_word_i = word;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    ops_sent++;
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (waiting > 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    drain_results();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cap_writes++;
  endtask

  initial begin
    int r;
    logic [2:0] op;
    in_valid_i  = 1'b0;
    operation_i = OP_APPEND;
    position_i  = '0;
    data_word_i = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty list: get out of range, search matches every cleared slot
    push_op(OP_GET, 4'd0, 32'h0);
    push_op(OP_SEARCH, 4'd0, 32'h0);
    push_op(OP_APPEND, 4'd0, 32'h7fff_ffff);
    push_op(OP_APPEND, 4'd0, 32'h8000_0000);
    push_op(OP_APPEND, 4'd0, 32'hffff_ffff);
    push_op(OP_INSERT, 4'd0, 32'h0000_0005);
    push_op(OP_INSERT, 4'd4, 32'h0000_0123);
    push_op(OP_INSERT, 4'd15, 32'h1111_1111);
    push_op(OP_SET, 4'd15, 32'h8000_0000);
    push_op(OP_SET, 4'd9, 32'h5a5a_5a5a);
    push_op(OP_GET, 4'd0, 32'h0);
    push_op(OP_GET, 4'd4, 32'h0);
    push_op(OP_GET, 4'd5, 32'h0);
    push_op(OP_GET, 4'd15, 32'h0);
    push_op(OP_SEARCH, 4'd0, 32'h8000_0000);
    push_op(OP_SEARCH, 4'd0, 32'hffff_ffff);
    push_op(OP_SEARCH, 4'd0, 32'hdead_beef);
    push_op(OP_UNDEF_LO, 4'd3, 32'h1234_5678);
    push_op(OP_UNDEF_LO + 3'd1, 4'd7, 32'h0);
    push_op(OP_UNDEF_HI, 4'd15, 32'hffff_ffff);

    // zero capacity acts as one slot, below the current fill
    write_capacity(5'd0);
    push_op(OP_APPEND, 4'd0, 32'h0000_0042);
    push_op(OP_INSERT, 4'd0, 32'h0000_0042);
    push_op(OP_SET, 4'd0, 32'h7fff_ffff);
    push_op(OP_SET, 4'd1, 32'h0000_0042);
    push_op(OP_GET, 4'd3, 32'h0);
    push_op(OP_SEARCH, 4'd0, 32'h7fff_ffff);

    for (int p = 0; p < 4; p++) begin
      write_capacity(phase_cap[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      repeat (24) begin
        r = $urandom_range(99);
        if (r < 12) op = OP_APPEND;
        else if (r < 24) op = OP_INSERT;
        else if (r < 44) op = OP_SET;
        else if (r < 64) op = OP_GET;
        else if (r < 94) op = OP_SEARCH;
        else op = 3'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
        push_op(op, 4'($urandom_range(15)),
                $urandom_range(1) ? word_pool[$urandom_range(3)] : $urandom);
      end
    end

    idle_pct  = 0;
    stall_pct = 0;
    drain_results();
    if (waiting != 0) $error("%0d expected results never arrived", waiting);
    $display("Ran %0d list operations with %0d results checked, across %0d capacity writes",
             ops_sent, checked, cap_writes);
    $display("and four handshake mixes from free flow to heavy idling and stalling.");
    if (fail_count == 0 && waiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: bounded_array_list_engine.f
src/bale_pkg.sv
src/bale_dp.sv
src/bale_ctrl.sv
src/bounded_array_list_engine.sv
src/bale_checker.sv
tb/bale_list_checker.sv
tb/tb_bounded_array_list_engine.sv
